/* hdl/wps_pkg.sv */
// Shared types and constants for the weld pulse sequencer.
// No dependencies; imported by weld_pulse_sequencer_unit.
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_START_DELAY = 3'd0;
  localparam logic [2:0] REG_PREHEAT     = 3'd1;
  localparam logic [2:0] REG_GAP         = 3'd2;
  localparam logic [2:0] REG_PULSE       = 3'd3;
  localparam logic [2:0] REG_PULSE_COUNT = 3'd4;
  localparam logic [2:0] REG_THRESHOLD   = 3'd5;
  localparam logic [2:0] REG_MODE        = 3'd6;

  // Weld mode codes; the fourth code is undefined and keeps the switch off.
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_HOLD   = 2'd2;

  localparam logic [5:0]  MAX_PULSES   = 6'd50;
  localparam logic [6:0]  WELD_SAT     = 7'd99;
  localparam logic [6:0]  MV_PER_TENTH = 7'd100;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [10:0] START_DELAY_RST = 11'd800;
  localparam logic [7:0]  PREHEAT_RST     = 8'd10;
  localparam logic [6:0]  GAP_RST         = 7'd10;
  localparam logic [7:0]  PULSE_RST       = 8'd30;
  localparam logic [5:0]  PULSE_COUNT_RST = 6'd5;
  localparam logic [5:0]  THRESHOLD_RST   = 6'd6;

  // One result beat.
  typedef struct packed {
    logic       weld_drive;
    logic       charge_inhibit;
    logic       weld_active;
    logic [6:0] welds_done;
    logic       is_armed;
  } wps_result_t;

endpackage

`default_nettype wire

/* hdl/weld_pulse_sequencer_unit.sv */
// Weld pulse sequencer: an accepted tick beat's result beat is registered; throughput
// one tick beat per cycle unless stalled. A two-entry output stage (result register plus
// skid register) keeps accepting while a result waits, and in_stall is registered.
// Reset (rst, synchronous, active high) clears all sequence state, empties the output
// stage and loads the configuration registers with their default values.
// Depends on wps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module weld_pulse_sequencer_unit
  import wps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [12:0] workpiece_mv,
  input  wire logic        trigger_pressed,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             weld_drive,
  output logic             charge_inhibit,
  output logic             weld_active,
  output logic [6:0]       welds_done,
  output logic             is_armed,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands on the access phase of the bus.
  // ---------------------------------------------------------------------------
  logic [10:0] start_delay_ms;
  logic [7:0]  preheat_ms;
  logic [6:0]  gap_ms;
  logic [7:0]  pulse_ms;
  logic [5:0]  pulse_count;
  logic [5:0]  contact_threshold;
  logic [1:0]  weld_mode;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay_ms    <= START_DELAY_RST;
      preheat_ms        <= PREHEAT_RST;
      gap_ms            <= GAP_RST;
      pulse_ms          <= PULSE_RST;
      pulse_count       <= PULSE_COUNT_RST;
      contact_threshold <= THRESHOLD_RST;
      weld_mode         <= MODE_AUTO;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_DELAY: start_delay_ms    <= pwdata[10:0];
        REG_PREHEAT:     preheat_ms        <= pwdata[7:0];
        REG_GAP:         gap_ms            <= pwdata[6:0];
        REG_PULSE:       pulse_ms          <= pwdata[7:0];
        REG_PULSE_COUNT: pulse_count       <= pwdata[5:0];
        REG_THRESHOLD:   contact_threshold <= pwdata[5:0];
        REG_MODE:        weld_mode         <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_START_DELAY: prdata = {21'd0, start_delay_ms};
      REG_PREHEAT:     prdata = {24'd0, preheat_ms};
      REG_GAP:         prdata = {25'd0, gap_ms};
      REG_PULSE:       prdata = {24'd0, pulse_ms};
      REG_PULSE_COUNT: prdata = {26'd0, pulse_count};
      REG_THRESHOLD:   prdata = {26'd0, contact_threshold};
      REG_MODE:        prdata = {30'd0, weld_mode};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequence state. Times are in ticks from arming (auto mode: from contact).
  // ---------------------------------------------------------------------------
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [5:0]  pulse_index, pulse_index_next;
  logic        active_flag, active_flag_next;
  logic        armed_flag, armed_flag_next;
  logic [6:0]  weld_count, weld_count_next;
  logic        drive_level, drive_level_next;

  // Output stage: a result register and a skid register behind it.
  wps_result_t out_data, skid_data, result;
  logic        skid_valid;
  logic        accept, pop;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // ---------------------------------------------------------------------------
  // Timing thresholds. The schedule is: low until start_delay, preheat high until
  // th1, then per window gap_ms low and pulse_ms high. Each bound is one small
  // multiply (period by a six-bit count) plus adds, then a compare.
  // ---------------------------------------------------------------------------
  logic [5:0]  num_pulses;
  logic [11:0] th1;
  logic [8:0]  period;
  logic [14:0] period_x_n;
  logic [14:0] period_x_idx;
  logic [15:0] total_ms;
  logic [15:0] win_lo;
  logic [15:0] win_hi;
  logic [12:0] contact_mv;
  logic        contact;

  assign num_pulses   = (pulse_count > MAX_PULSES) ? MAX_PULSES : pulse_count;
  assign th1          = 12'(start_delay_ms) + 12'(preheat_ms);
  assign period       = 9'(gap_ms) + 9'(pulse_ms);
  assign period_x_n   = 15'(period) * 15'(num_pulses);
  assign period_x_idx = 15'(period) * 15'(pulse_index);
  assign total_ms     = 16'(period_x_n) + 16'(th1);
  assign win_lo       = 16'(period_x_idx) + 16'(gap_ms) + 16'(th1);
  assign win_hi       = win_lo + 16'(pulse_ms);
  assign contact_mv   = 13'(contact_threshold) * 13'(MV_PER_TENTH);
  assign contact      = workpiece_mv > contact_mv;

  // ---------------------------------------------------------------------------
  // Next-state logic for one tick.
  // ---------------------------------------------------------------------------
  logic run_seq;
  logic count_welds;
  logic clear_arm;
  logic inhibit;

  always_comb begin
    elapsed_ms_next  = elapsed_ms;
    pulse_index_next = pulse_index;
    active_flag_next = active_flag;
    armed_flag_next  = armed_flag;
    weld_count_next  = weld_count;
    drive_level_next = drive_level;
    run_seq          = 1'b0;
    count_welds      = 1'b0;
    clear_arm        = 1'b0;
    inhibit          = 1'b0;

    case (weld_mode)
      MODE_AUTO: begin
        if (contact || active_flag) begin
          run_seq     = 1'b1;
          count_welds = 1'b1;
        end else begin
          elapsed_ms_next  = '0;
          drive_level_next = 1'b0;
        end
      end
      MODE_MANUAL: begin
        // The trigger arms; the sequence itself waits for workpiece contact,
        // while the time counter already runs from the arming tick.
        armed_flag_next = armed_flag || trigger_pressed;
        if (armed_flag || trigger_pressed) begin
          if (contact || active_flag) begin
            run_seq   = 1'b1;
            clear_arm = 1'b1;
          end else if (elapsed_ms != ELAPSED_MAX) begin
            elapsed_ms_next = elapsed_ms + 16'd1;
          end
        end else begin
          elapsed_ms_next  = '0;
          drive_level_next = 1'b0;
        end
      end
      MODE_HOLD: begin
        inhibit          = trigger_pressed;
        drive_level_next = trigger_pressed;
        active_flag_next = trigger_pressed;
      end
      default: begin
        drive_level_next = 1'b0;
      end
    endcase

    if (run_seq) begin
      active_flag_next = 1'b1;
      if (elapsed_ms <= total_ms) begin
        inhibit = 1'b1;
        if (elapsed_ms < 16'(start_delay_ms)) begin
          drive_level_next = 1'b0;
        end else if (elapsed_ms < 16'(th1)) begin
          drive_level_next = 1'b1;
        end else if (pulse_index < num_pulses) begin
          if (elapsed_ms < win_lo) begin
            drive_level_next = 1'b0;
          end else if (elapsed_ms < win_hi) begin
            drive_level_next = 1'b1;
          end else begin
            // Window end: step to the next window with the switch off.
            pulse_index_next = pulse_index + 6'd1;
            drive_level_next = 1'b0;
          end
        end else if (count_welds && (pulse_index <= num_pulses)) begin
          // Auto, all windows done: count the weld once, park the index past the end.
          pulse_index_next = num_pulses + 6'd1;
          if (weld_count < WELD_SAT) begin
            weld_count_next = weld_count + 7'd1;
          end
        end
      end else begin
        // Sequence end. The time counter keeps running so that a contact or
        // trigger still present does not re-arm until it is released.
        active_flag_next = 1'b0;
        pulse_index_next = '0;
        drive_level_next = 1'b0;
        if (clear_arm) begin
          armed_flag_next = 1'b0;
        end
      end
      if (elapsed_ms != ELAPSED_MAX) begin
        elapsed_ms_next = elapsed_ms + 16'd1;
      end
    end
  end

  always_comb begin
    result.weld_drive     = drive_level_next;
    result.charge_inhibit = inhibit;
    result.weld_active    = (weld_mode == MODE_HOLD || weld_mode == MODE_MANUAL ||
                             weld_mode == MODE_AUTO) ? active_flag_next : 1'b0;
    result.welds_done     = weld_count_next;
    result.is_armed       = armed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms  <= '0;
      pulse_index <= '0;
      active_flag <= 1'b0;
      armed_flag  <= 1'b0;
      weld_count  <= '0;
      drive_level <= 1'b0;
    end else if (accept) begin
      elapsed_ms  <= elapsed_ms_next;
      pulse_index <= pulse_index_next;
      active_flag <= active_flag_next;
      armed_flag  <= armed_flag_next;
      weld_count  <= weld_count_next;
      drive_level <= drive_level_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage. A new result goes to the result register when it is empty or
  // being drained, otherwise into the skid register, which then holds off input.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign weld_drive     = out_data.weld_drive;
  assign charge_inhibit = out_data.charge_inhibit;
  assign weld_active    = out_data.weld_active;
  assign welds_done     = out_data.welds_done;
  assign is_armed       = out_data.is_armed;

`ifndef NO_ASSERTIONS
  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat while the result register is empty");

  // Every accepted tick leaves a result beat pending on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick beat produced no result beat");

  // The window index never runs past one beyond the largest pulse count.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    pulse_index <= (MAX_PULSES + 6'd1))
    else $error("pulse index out of range");

  // The weld counter saturates.
  a_weld_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (welds_done <= WELD_SAT))
    else $error("weld count above saturation limit");
`endif

endmodule

`default_nettype wire
